>>> rtl/porter_duff_pixel_blend_macros.svh
// Assertion macros shared by the checker.
`ifndef PORTER_DUFF_PIXEL_BLEND_MACROS_SVH
`define PORTER_DUFF_PIXEL_BLEND_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define PDB_ASSERT_IMP(lbl, clk, rst_n, a, c, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
// Next-cycle implication.
`define PDB_ASSERT_NEXT(lbl, clk, rst_n, a, c, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`endif

>>> rtl/pdb_pkg.sv
package pdb_pkg;
	typedef enum logic [3:0] {
		MODE_CLEAR = 4'd0, MODE_SRC = 4'd1, MODE_DST = 4'd2, MODE_SRC_OVER = 4'd3,
		MODE_DST_OVER = 4'd4, MODE_SRC_IN = 4'd5, MODE_DST_IN = 4'd6,
		MODE_SRC_OUT = 4'd7, MODE_DST_OUT = 4'd8, MODE_SRC_ATOP = 4'd9,
		MODE_DST_ATOP = 4'd10, MODE_XOR = 4'd11, MODE_DARKEN = 4'd12,
		MODE_LIGHTEN = 4'd13, MODE_KEEP_A = 4'd14, MODE_KEEP_B = 4'd15
	} mode_t;

	localparam logic [3:0] ModeReset = 4'd3;
	localparam logic [0:0] RegBlendMode = 1'b0;

	// Classified pixel beat handed from front to back.
	typedef struct packed {
		logic [31:0] src;
		logic [31:0] dst;
		logic [7:0]  cov;
		logic        last;
		mode_t       mode;
		logic        pass;  // result is the destination
		logic        full;  // no interpolation needed
	} beat_t;

	// (a*b*257 + 257) >> 16 for 8-bit operands.
	function automatic logic [7:0] mul8(input logic [7:0] a, input logic [7:0] b);
		logic [15:0] p;
		logic [24:0] t;
		p = a * b;
		t = 25'(p) * 25'd257 + 25'd257;
		return t[23:16];
	endfunction
endpackage

>>> rtl/pdb_front.sv
module pdb_front
	import pdb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_vld,
	input  logic [31:0] src_pixel,
	input  logic [31:0] dst_pixel,
	input  logic [7:0]  coverage,
	input  logic        span_last,
	input  mode_t       mode,
	output logic        out_vld,
	output beat_t       out_beat
);
	beat_t b_d;

	// Classify the beat: destination pass-through and full coverage.
	always_comb begin
		b_d.src  = src_pixel;
		b_d.dst  = dst_pixel;
		b_d.cov  = coverage;
		b_d.last = span_last;
		b_d.mode = mode;
		b_d.pass = (coverage == 8'd0) || (mode == MODE_KEEP_A) || (mode == MODE_KEEP_B);
		b_d.full = (coverage == 8'hFF);
	end

	// Queue slot between the front and the back.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld <= 1'b0;
		end else begin
			out_vld <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		out_beat <= b_d;
	end
endmodule

>>> rtl/pdb_back.sv
module pdb_back
	import pdb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_vld,
	input  beat_t       in_beat,
	output logic        out_vld,
	output logic [31:0] result_pixel,
	output logic        span_last_out
);
	logic [31:0] mres;
	logic [31:0] res_d;
	logic        vld_s1;
	beat_t       b_s1;
	logic [31:0] mres_s1;

	// Mode result for one pixel.
	always_comb begin
		logic [7:0] sa, da, ra, m, sc, dc;
		logic [8:0] ks, kd;
		logic [17:0] v;
		logic [9:0] w;
		mres = 32'd0;
		sa = in_beat.src[31:24];
		da = in_beat.dst[31:24];
		ra = 8'd0;
		ks = 9'd0;
		kd = 9'd0;
		m = 8'd0;
		sc = 8'd0;
		dc = 8'd0;
		v = 18'd0;
		w = 10'd0;
		case (in_beat.mode)
			MODE_SRC: mres = in_beat.src;
			MODE_DST: mres = in_beat.dst;
			MODE_SRC_OVER, MODE_DST_OUT, MODE_SRC_IN, MODE_DST_IN, MODE_SRC_OUT: begin
				for (int i = 0; i < 4; i++) begin
					if (in_beat.mode == MODE_SRC_IN || in_beat.mode == MODE_SRC_OUT)
						sc = in_beat.src[8*i +: 8];
					else
						sc = in_beat.dst[8*i +: 8];
					if (in_beat.mode == MODE_SRC_IN) ks = {1'b0, da} + 9'd1;
					else if (in_beat.mode == MODE_DST_IN) ks = {1'b0, sa} + 9'd1;
					else if (in_beat.mode == MODE_SRC_OUT) ks = 9'd256 - {1'b0, da};
					else ks = 9'd256 - {1'b0, sa};
					v = 18'(sc) * 18'(ks);
					mres[8*i +: 8] = v[15:8];
					if (in_beat.mode == MODE_SRC_OVER)
						mres[8*i +: 8] = v[15:8] + in_beat.src[8*i +: 8];
				end
			end
			MODE_DST_OVER: begin
				mres[31:24] = sa + da - mul8(sa, da);
				for (int i = 0; i < 3; i++)
					mres[8*i +: 8] = in_beat.dst[8*i +: 8]
						+ mul8(8'hFF - da, in_beat.src[8*i +: 8]);
			end
			MODE_SRC_ATOP, MODE_DST_ATOP, MODE_XOR: begin
				if (in_beat.mode == MODE_SRC_ATOP) begin
					ra = da; ks = {1'b0, da} + 9'd1; kd = 9'd256 - {1'b0, sa};
				end else if (in_beat.mode == MODE_DST_ATOP) begin
					ra = sa; ks = 9'd256 - {1'b0, da}; kd = {1'b0, sa} + 9'd1;
				end else begin
					ra = 8'(sa + da - {mul8(sa, da), 1'b0});
					ks = 9'd256 - {1'b0, da}; kd = 9'd256 - {1'b0, sa};
				end
				mres[31:24] = ra;
				for (int i = 0; i < 3; i++) begin
					v = 18'(in_beat.src[8*i +: 8]) * 18'(ks)
						+ 18'(in_beat.dst[8*i +: 8]) * 18'(kd);
					mres[8*i +: 8] = v[15:8];
				end
			end
			MODE_DARKEN, MODE_LIGHTEN: begin
				ra = sa + da - mul8(sa, da);
				ks = 9'd256 - {1'b0, da};
				kd = 9'd256 - {1'b0, sa};
				mres[31:24] = ra;
				for (int i = 0; i < 3; i++) begin
					sc = in_beat.src[8*i +: 8];
					dc = in_beat.dst[8*i +: 8];
					if (in_beat.mode == MODE_LIGHTEN) m = (sc > dc) ? sc : dc;
					else m = (sc < dc) ? sc : dc;
					v = 18'(sc) * 18'(ks) + 18'(dc) * 18'(kd);
					// The sum can reach 765, so it is compared at full width.
					w = v[17:8] + {2'b0, m};
					mres[8*i +: 8] = (w < {2'b0, ra}) ? w[7:0] : ra;
				end
			end
			default: mres = 32'd0;
		endcase
	end

	// Stage 1 holds the mode result; stage 2 interpolates.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			out_vld <= 1'b0;
		end else begin
			vld_s1  <= in_vld;
			out_vld <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		b_s1    <= in_beat;
		mres_s1 <= mres;
	end

	// Coverage handling: clear, pass, full, or interpolate toward destination.
	always_comb begin
		logic [8:0] k;
		logic signed [18:0] t;
		logic [7:0] d;
		res_d = 32'd0;
		k = {1'b0, b_s1.cov} + 9'd1;
		t = '0;
		d = 8'd0;
		if (b_s1.pass) begin
			res_d = b_s1.dst;
		end else if (b_s1.mode == MODE_CLEAR) begin
			for (int i = 0; i < 4; i++) begin
				t = 19'(b_s1.dst[8*i +: 8]) * 19'(9'd256 - {1'b0, b_s1.cov});
				res_d[8*i +: 8] = b_s1.full ? 8'd0 : t[15:8];
			end
		end else if (b_s1.full) begin
			res_d = mres_s1;
		end else begin
			for (int i = 0; i < 4; i++) begin
				d = b_s1.dst[8*i +: 8];
				t = (19'sd0 + $signed({11'd0, mres_s1[8*i +: 8]}) - $signed({11'd0, d}))
					* $signed({10'd0, k}) + 19'sd65536;
				res_d[8*i +: 8] = d + t[15:8];
			end
		end
	end

	always_ff @(posedge clk) begin
		result_pixel  <= res_d;
		span_last_out <= b_s1.last;
	end
endmodule

>>> rtl/porter_duff_pixel_blend.sv
// Channel   | Dir | Handshake                      | Beat
// command   | in  | start & !busy                  | src_pixel, dst_pixel, coverage, span_last
// result    | out | done (one cycle, no stall)     | result_pixel, span_last_out
// config    | in  | psel & penable & pwrite        | blend_mode at byte address 0
// One pixel is taken every cycle; busy is always low.
// Each pixel passes the front queue slot, the mode stage and the interpolation stage, in that order.
// Throughput is one pixel a cycle; the mode stage does up to two multiplies per channel
// and the interpolation stage one.
// Reset clears the valid pipeline and sets blend_mode to source over.
module porter_duff_pixel_blend
	import pdb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] src_pixel,
	input  logic [31:0] dst_pixel,
	input  logic [7:0]  coverage,
	input  logic        span_last,
	output logic        done,
	output logic [31:0] result_pixel,
	output logic        span_last_out,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [0:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	mode_t mode_q;
	logic  q_vld;
	beat_t q_beat;

	assign busy   = 1'b0;
	assign pready = 1'b1;
	assign prdata = (paddr == RegBlendMode) ? {28'd0, mode_q} : 32'd0;

	// Mode register write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= mode_t'(ModeReset);
		end else if (psel && penable && pwrite && paddr == RegBlendMode) begin
			mode_q <= mode_t'(pwdata[3:0]);
		end
	end

	pdb_front u_front (
		.clk(clk), .arst_n(arst_n), .in_vld(start && !busy),
		.src_pixel(src_pixel), .dst_pixel(dst_pixel), .coverage(coverage),
		.span_last(span_last), .mode(mode_q), .out_vld(q_vld), .out_beat(q_beat)
	);

	pdb_back u_back (
		.clk(clk), .arst_n(arst_n), .in_vld(q_vld), .in_beat(q_beat),
		.out_vld(done), .result_pixel(result_pixel), .span_last_out(span_last_out)
	);
endmodule

>>> rtl/pdb_checker.sv
`include "porter_duff_pixel_blend_macros.svh"
module pdb_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       done,
	input logic       span_last,
	input logic       span_last_out,
	input logic [7:0] coverage,
	input logic [31:0] dst_pixel,
	input logic [31:0] result_pixel
);
	// Every accepted beat produces a result.
	`PDB_ASSERT_IMP(a_lat, clk, arst_n, $past(start && !busy, 3), done, "missing result")
	// No result without an accepted beat before it.
	`PDB_ASSERT_IMP(a_noext, clk, arst_n, done, $past(start && !busy, 3), "spurious result")
	// Span marker follows its pixel.
	`PDB_ASSERT_IMP(a_last, clk, arst_n, done, span_last_out == $past(span_last, 3), "span mark")
	// Zero coverage returns the destination.
	`PDB_ASSERT_IMP(a_zero, clk, arst_n, done && $past(coverage == 8'd0, 3),
		result_pixel == $past(dst_pixel, 3), "zero coverage")
endmodule

bind porter_duff_pixel_blend pdb_checker u_chk (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.span_last(span_last), .span_last_out(span_last_out), .coverage(coverage),
	.dst_pixel(dst_pixel), .result_pixel(result_pixel)
);

>>> tb/sv/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import pdb_pkg::*;

	localparam int StallLimit = 5000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [31:0] src_pixel = '0;
	logic [31:0] dst_pixel = '0;
	logic [7:0]  coverage = '0;
	logic        span_last = 1'b0;
	logic        done;
	logic [31:0] result_pixel;
	logic        span_last_out;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [0:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	typedef struct {
		logic [31:0] pixel;
		logic        last;
	} blended_t;

	blended_t blended_q[$];
	mode_t    cur_mode = mode_t'(ModeReset);
	int       mismatches = 0;
	int       stall_cycles = 0;
	bit       no_gaps = 1'b0;

	porter_duff_pixel_blend dut (.*);

	always #5 clk = ~clk;

	// Blend arithmetic, one 8-bit channel at a time.
	function automatic int chan(logic [31:0] p, int sh);
		return (p >> sh) & 255;
	endfunction

	function automatic logic [31:0] pack4(int a, int r, int g, int b);
		logic [7:0] a8, r8, g8, b8;
		a8 = a[7:0];
		r8 = r[7:0];
		g8 = g[7:0];
		b8 = b[7:0];
		return {a8, r8, g8, b8};
	endfunction

	function automatic int mul_255(int a, int b);
		return (a * b * 257 + 257) >> 16;
	endfunction

	function automatic logic [31:0] scale_px(logic [31:0] c, int s);
		return pack4((chan(c, 24) * s) >> 8, (chan(c, 16) * s) >> 8,
			(chan(c, 8) * s) >> 8, (chan(c, 0) * s) >> 8);
	endfunction

	function automatic int lerp_chan(int s, int d, int k);
		int t;
		t = (s - d) * k + 65536;
		return (d + (t >>> 8) - 256) & 255;
	endfunction

	function automatic logic [31:0] mix_px(logic [31:0] s, logic [31:0] d, int a, int ks,
			int kd);
		return pack4(a, (ks * chan(s, 16) + kd * chan(d, 16)) >> 8,
			(ks * chan(s, 8) + kd * chan(d, 8)) >> 8,
			(ks * chan(s, 0) + kd * chan(d, 0)) >> 8);
	endfunction

	function automatic int minmax_chan(int sc, int dc, int ks, int kd, int ra, bit lighter);
		int m, v;
		m = lighter ? (sc > dc ? sc : dc) : (sc < dc ? sc : dc);
		v = ((ks * sc + kd * dc) >> 8) + m;
		return v < ra ? v : ra;
	endfunction

	// Full-coverage compositing result for the current mode.
	function automatic logic [31:0] composite(mode_t m, logic [31:0] s, logic [31:0] d);
		int sa, da, ra, sh;
		logic [31:0] o, t;
		sa = chan(s, 24);
		da = chan(d, 24);
		o = '0;
		case (m)
			MODE_SRC: o = s;
			MODE_DST: o = d;
			MODE_SRC_OVER: begin
				t = scale_px(d, 256 - sa);
				o = pack4(chan(s, 24) + chan(t, 24), chan(s, 16) + chan(t, 16),
					chan(s, 8) + chan(t, 8), chan(s, 0) + chan(t, 0));
			end
			MODE_DST_OVER: o = pack4(sa + da - mul_255(sa, da),
				chan(d, 16) + mul_255(255 - da, chan(s, 16)),
				chan(d, 8) + mul_255(255 - da, chan(s, 8)),
				chan(d, 0) + mul_255(255 - da, chan(s, 0)));
			MODE_SRC_IN: o = scale_px(s, da + 1);
			MODE_DST_IN: o = scale_px(d, sa + 1);
			MODE_SRC_OUT: o = scale_px(s, 256 - da);
			MODE_DST_OUT: o = scale_px(d, 256 - sa);
			MODE_SRC_ATOP: o = mix_px(s, d, da, da + 1, 256 - sa);
			MODE_DST_ATOP: o = mix_px(s, d, sa, 256 - da, sa + 1);
			MODE_XOR: o = mix_px(s, d, sa + da - 2 * mul_255(sa, da), 256 - da, 256 - sa);
			MODE_DARKEN, MODE_LIGHTEN: begin
				ra = sa + da - mul_255(sa, da);
				o[31:24] = ra[7:0];
				for (sh = 0; sh < 24; sh += 8)
					o[sh +: 8] = 8'(minmax_chan(chan(s, sh), chan(d, sh), 256 - da,
						256 - sa, ra, m == MODE_LIGHTEN));
			end
			default: o = '0;
		endcase
		return o;
	endfunction

	// New destination pixel including coverage handling.
	function automatic logic [31:0] blended_pixel(mode_t m, logic [31:0] s, logic [31:0] d,
			logic [7:0] cov);
		logic [31:0] r;
		int sh;
		if (cov == 8'd0 || m == MODE_KEEP_A || m == MODE_KEEP_B)
			return d;
		if (m == MODE_CLEAR)
			return (cov == 8'd255) ? 32'd0 : scale_px(d, 256 - cov);
		r = composite(m, s, d);
		if (cov != 8'd255)
			for (sh = 0; sh < 32; sh += 8)
				r[sh +: 8] = 8'(lerp_chan(chan(r, sh), chan(d, sh), cov + 1));
		return r;
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		mismatches++;
		$display("mismatch %s: got %h, expected %h at %0t", what, got, want, $realtime);
	endtask

	// Compare each result beat with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (blended_q.size() == 0) begin
				report("unexpected result", result_pixel, '0);
			end else begin
				if (result_pixel !== blended_q[0].pixel)
					report("result_pixel", result_pixel, blended_q[0].pixel);
				if (span_last_out !== blended_q[0].last)
					report("span_last_out", 32'(span_last_out), 32'(blended_q[0].last));
				void'(blended_q.pop_front());
			end
		end
	end

	// Watchdog on cycles in which nothing moves.
	always @(posedge clk) begin
		if (!arst_n || done || (start && !busy) || (psel && penable))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= StallLimit) begin
			$display("simulation failed");
			$finish;
		end
	end

	function automatic int gap_len();
		int r;
		if (no_gaps)
			return 0;
		r = $urandom_range(99);
		if (r < 65)
			return 0;
		if (r < 95)
			return $urandom_range(3, 1);
		return $urandom_range(40, 10);
	endfunction

	// Send one pixel beat and record its expected result.
	task automatic send_pixel(logic [31:0] s, logic [31:0] d, logic [7:0] cov, logic last);
		int gap;
		blended_t e;
		@(negedge clk);
		start = 1'b1;
		src_pixel = s;
		dst_pixel = d;
		coverage = cov;
		span_last = last;
		do @(posedge clk); while (busy);
		e.pixel = blended_pixel(cur_mode, s, d, cov);
		e.last = last;
		blended_q.push_back(e);
		gap = gap_len();
		if (gap > 0) begin
			@(negedge clk);
			start = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic drain();
		@(negedge clk);
		start = 1'b0;
		while (blended_q.size() != 0) @(posedge clk);
		repeat (5) @(posedge clk);
	endtask

	// Register write and read back, only with the pipeline empty.
	task automatic set_mode(mode_t m);
		drain();
		@(negedge clk);
		psel = 1'b1;
		pwrite = 1'b1;
		paddr = RegBlendMode;
		pwdata = {$urandom_range(32'hFFFF) << 4} | 32'(m);
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		cur_mode = m;
		@(negedge clk);
		pwrite = 1'b0;
		penable = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[3:0] !== m)
			report("blend_mode read back", prdata, 32'(m));
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
	endtask

	function automatic logic [31:0] rand_pixel();
		int r;
		r = $urandom_range(9);
		if (r == 0)
			return 32'd0;
		if (r == 1)
			return 32'hFFFFFFFF;
		return $urandom;
	endfunction

	function automatic logic [7:0] rand_cov();
		int r;
		r = $urandom_range(9);
		if (r < 2)
			return 8'd255;
		if (r == 2)
			return 8'd0;
		return 8'($urandom_range(255));
	endfunction

	// Field extremes and every mode with full, partial and zero coverage.
	task automatic test_directed();
		mode_t m;
		send_pixel(32'hFFFFFFFF, 32'h00000000, 8'd255, 1'b1);
		send_pixel(32'h00000000, 32'hFFFFFFFF, 8'd255, 1'b0);
		send_pixel(32'h80402010, 32'hFF7F3F1F, 8'd0, 1'b1);
		for (int i = 0; i < 16; i++) begin
			m = mode_t'(i);
			set_mode(m);
			send_pixel(32'hFFFFFFFF, 32'hFFFFFFFF, 8'd255, 1'b1);
			send_pixel(32'h80FF00FF, 32'hC0FFFF00, 8'd1, 1'b0);
			send_pixel(32'h7F102030, 32'hFF0000FF, 8'd128, 1'b1);
			send_pixel(32'hFFFFFFFF, 32'h00000000, 8'd254, 1'b0);
			send_pixel(32'h12345678, 32'h87654321, 8'd0, 1'b1);
		end
	endtask

	// Random pixels in phases of random modes, the extremes included.
	task automatic test_random_modes();
		mode_t m;
		for (int p = 0; p < 18; p++) begin
			if (p == 0)
				m = MODE_CLEAR;
			else if (p == 1)
				m = MODE_KEEP_B;
			else
				m = mode_t'($urandom_range(15));
			set_mode(m);
			no_gaps = ($urandom_range(3) == 0);
			for (int i = 0; i < 60; i++)
				send_pixel(rand_pixel(), rand_pixel(), rand_cov(), 1'($urandom_range(1)));
		end
		no_gaps = 1'b0;
	endtask

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_random_modes();
		drain();
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
